// ===== rtl/bir_pkg.sv =====
`timescale 1ns / 1ps

package bir_pkg;

    // Field widths of the stream items
    localparam int ROW_W  = 5;
    localparam int COL_W  = 5;
    localparam int PIX_W  = 8;
    localparam int ANG_W  = 16;

    // Offset from center, product and source-coordinate widths
    localparam int OFS_W  = 7;
    localparam int PROD_W = OFS_W + ANG_W;
    localparam int SUM_W  = 25;

    // Four image banks split by row and column parity
    localparam int NBANK  = 4;

    // Command codes carried in tuser
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // Configuration register indexes
    localparam int   REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_COS = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SIN = 1'b1;

    localparam logic signed [ANG_W-1:0] COS_RESET = 16'sd16384;
    localparam logic signed [ANG_W-1:0] SIN_RESET = 16'sd0;

    // One beat after the rotation: command, write payload, source coordinate
    typedef struct packed {
        logic                    cmd;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic [PIX_W-1:0]        pix;
        logic signed [SUM_W-1:0] src_row;
        logic signed [SUM_W-1:0] src_col;
    } coord_t;

    // Neighbour bookkeeping that travels beside the bank read data
    typedef struct packed {
        logic row_par;
        logic col_par;
        logic row0_ok;
        logic row1_ok;
        logic col0_ok;
        logic col1_ok;
    } nbr_ctl_t;

endpackage

// ===== rtl/bir_ram.sv =====
`timescale 1ns / 1ps

module bir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bir_coord.sv =====
`timescale 1ns / 1ps

module bir_coord #(
    parameter int IMG_ROWS  = 28,
    parameter int IMG_COLS  = 28,
    parameter int FRAC_BITS = 14
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_cmd,
    input  logic [bir_pkg::ROW_W-1:0]            in_row,
    input  logic [bir_pkg::COL_W-1:0]            in_col,
    input  logic [bir_pkg::PIX_W-1:0]            in_pix,
    input  logic signed [bir_pkg::ANG_W-1:0]     cos_angle,
    input  logic signed [bir_pkg::ANG_W-1:0]     sin_angle,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output bir_pkg::coord_t                      out_coord
);

    import bir_pkg::*;

    localparam logic signed [OFS_W-1:0] HALF_R = OFS_W'(IMG_ROWS / 2);
    localparam logic signed [OFS_W-1:0] HALF_C = OFS_W'(IMG_COLS / 2);
    localparam logic signed [SUM_W-1:0] CTR_R  = SUM_W'((IMG_ROWS / 2) << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] CTR_C  = SUM_W'((IMG_COLS / 2) << FRAC_BITS);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    // stage 1: input register
    logic             cmd1_reg;
    logic [ROW_W-1:0] row1_reg;
    logic [COL_W-1:0] col1_reg;
    logic [PIX_W-1:0] pix1_reg;

    // stage 2: rotation products
    logic             cmd2_reg;
    logic [ROW_W-1:0] row2_reg;
    logic [COL_W-1:0] col2_reg;
    logic [PIX_W-1:0] pix2_reg;
    logic signed [OFS_W-1:0]  y_off, x_off;
    logic signed [PROD_W-1:0] xc_next, xs_next, yc_next, ys_next;
    logic signed [PROD_W-1:0] xc_reg, xs_reg, yc_reg, ys_reg;

    // stage 3: source coordinate
    coord_t coord_next, coord_reg;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign y_off = $signed({2'b00, row1_reg}) - HALF_R;
    assign x_off = $signed({2'b00, col1_reg}) - HALF_C;

    assign xc_next = x_off * cos_angle;
    assign xs_next = x_off * sin_angle;
    assign yc_next = y_off * cos_angle;
    assign ys_next = y_off * sin_angle;

    always_comb begin
        coord_next.cmd     = cmd2_reg;
        coord_next.row     = row2_reg;
        coord_next.col     = col2_reg;
        coord_next.pix     = pix2_reg;
        coord_next.src_row = SUM_W'(xs_reg) + SUM_W'(yc_reg) + CTR_R;
        coord_next.src_col = SUM_W'(xc_reg) - SUM_W'(ys_reg) + CTR_C;
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            cmd1_reg <= in_cmd;
            row1_reg <= in_row;
            col1_reg <= in_col;
            pix1_reg <= in_pix;
        end
        if (rdy2) begin
            cmd2_reg <= cmd1_reg;
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
            pix2_reg <= pix1_reg;
            xc_reg   <= xc_next;
            xs_reg   <= xs_next;
            yc_reg   <= yc_next;
            ys_reg   <= ys_next;
        end
        if (rdy3) begin
            coord_reg <= coord_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_coord = coord_reg;

    // hold the coordinate while the store stage stalls
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !out_ready) |=> (v3_reg && $stable(coord_reg)))
        else $error("coordinate stage changed while stalled");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && rdy2) |=> v2_reg)
        else $error("beat lost between product stages");

endmodule

// ===== rtl/bir_store.sv =====
`timescale 1ns / 1ps

module bir_store #(
    parameter int IMG_ROWS  = 28,
    parameter int IMG_COLS  = 28,
    parameter int FRAC_BITS = 14
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  bir_pkg::coord_t                                in_coord,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output bir_pkg::nbr_ctl_t                              out_ctl,
    output logic [FRAC_BITS-1:0]                           out_frac_row,
    output logic [FRAC_BITS-1:0]                           out_frac_col,
    output logic [bir_pkg::NBANK-1:0][bir_pkg::PIX_W-1:0]  out_pix
);

    import bir_pkg::*;

    localparam int IW     = SUM_W - FRAC_BITS;
    localparam int HROWS  = (IMG_ROWS + 1) / 2;
    localparam int HCOLS  = (IMG_COLS + 1) / 2;
    localparam int ROW_AW = (HROWS > 1) ? $clog2(HROWS) : 1;
    localparam int COL_AW = (HCOLS > 1) ? $clog2(HCOLS) : 1;
    localparam int AW     = ROW_AW + COL_AW;
    localparam int DEPTH  = 1 << AW;

    localparam logic signed [IW-1:0] ROWS_S = IW'(IMG_ROWS);
    localparam logic signed [IW-1:0] COLS_S = IW'(IMG_COLS);
    localparam logic signed [IW-1:0] ONE_S  = IW'(1);

    logic                 v4_reg;
    logic                 rdy4;
    logic signed [IW-1:0] r0, r1, c0, c1;
    logic [IW-1:0]        wrow, wcol;
    logic                 wr_any;
    logic [AW-1:0]        wr_addr;
    nbr_ctl_t             ctl_next, ctl_reg;
    logic [FRAC_BITS-1:0] frac_row_reg, frac_col_reg;

    assign rdy4     = !v4_reg || out_ready;
    assign in_ready = rdy4;

    // floor and fraction of the source coordinate
    assign r0 = in_coord.src_row[SUM_W-1:FRAC_BITS];
    assign c0 = in_coord.src_col[SUM_W-1:FRAC_BITS];
    assign r1 = r0 + ONE_S;
    assign c1 = c0 + ONE_S;

    // writes commit in stream order, at the same point where reads issue
    assign wrow    = IW'(in_coord.row);
    assign wcol    = IW'(in_coord.col);
    assign wr_any  = rdy4 && in_valid && (in_coord.cmd == CMD_WRITE)
                     && ($signed(wrow) < ROWS_S) && ($signed(wcol) < COLS_S);
    assign wr_addr = {wrow[ROW_AW:1], wcol[COL_AW:1]};

    always_comb begin
        ctl_next.row_par = r0[0];
        ctl_next.col_par = c0[0];
        ctl_next.row0_ok = !r0[IW-1] && (r0 < ROWS_S);
        ctl_next.row1_ok = !r1[IW-1] && (r1 < ROWS_S);
        ctl_next.col0_ok = !c0[IW-1] && (c0 < COLS_S);
        ctl_next.col1_ok = !c1[IW-1] && (c1 < COLS_S);
    end

    for (genvar b = 0; b < NBANK; b++) begin : g_bank
        localparam logic [1:0] BID = 2'(b);
        logic [IW-1:0] rsel, csel;
        logic [AW-1:0] rd_addr;
        logic          we;

        // each bank holds one of the four neighbours
        assign rsel    = (r0[0] == BID[1]) ? r0 : r1;
        assign csel    = (c0[0] == BID[0]) ? c0 : c1;
        assign rd_addr = {rsel[ROW_AW:1], csel[COL_AW:1]};
        assign we      = wr_any && (in_coord.row[0] == BID[1])
                                && (in_coord.col[0] == BID[0]);

        bir_ram #(
            .WIDTH (PIX_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (we),
            .wr_addr (wr_addr),
            .wr_data (in_coord.pix),
            .rd_en   (rdy4),
            .rd_addr (rd_addr),
            .rd_data (out_pix[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            // drop writes here: they leave no result
            v4_reg <= in_valid && (in_coord.cmd == CMD_COMPUTE);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            ctl_reg      <= ctl_next;
            frac_row_reg <= in_coord.src_row[FRAC_BITS-1:0];
            frac_col_reg <= in_coord.src_col[FRAC_BITS-1:0];
        end
    end

    assign out_valid    = v4_reg;
    assign out_ctl      = ctl_reg;
    assign out_frac_row = frac_row_reg;
    assign out_frac_col = frac_col_reg;

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_any |=> !v4_reg)
        else $error("write beat produced a result slot");

    // off-image neighbours may read unwritten entries, so compare case-exact
    a_read_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !out_ready) |=>
            (v4_reg && (out_pix === $past(out_pix)) && $stable(ctl_reg)))
        else $error("bank read data changed while stalled");

endmodule

// ===== rtl/bir_blend.sv =====
`timescale 1ns / 1ps

module bir_blend #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  bir_pkg::nbr_ctl_t                              in_ctl,
    input  logic [FRAC_BITS-1:0]                           in_frac_row,
    input  logic [FRAC_BITS-1:0]                           in_frac_col,
    input  logic [bir_pkg::NBANK-1:0][bir_pkg::PIX_W-1:0]  in_pix,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output logic [bir_pkg::PIX_W-1:0]                      out_pixel
);

    import bir_pkg::*;

    localparam int WT_W   = FRAC_BITS + 1;
    localparam int WW     = 2 * FRAC_BITS + 1;
    localparam int TERM_W = WW + PIX_W;
    localparam int ACC_W  = TERM_W + 2;
    localparam int SH     = 2 * FRAC_BITS;
    localparam int RES_W  = ACC_W - SH;

    localparam logic [WT_W-1:0]  ONE_W   = WT_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF_A  = ACC_W'(1) << (SH - 1);
    localparam logic [WW+1:0]    ONE_SQ  = (WW + 2)'(1) << SH;

    logic v5_reg, v6_reg, v7_reg;
    logic rdy5, rdy6, rdy7;

    logic [WT_W-1:0] fr, fc, wr0, wc0;
    logic [NBANK-1:0][WW-1:0]     w_next, w_reg;
    logic [NBANK-1:0][PIX_W-1:0]  p_next, p_reg;
    logic [NBANK-1:0][TERM_W-1:0] t_next, t_reg;
    logic [ACC_W-1:0]             acc;
    logic [RES_W-1:0]             res;
    logic [PIX_W-1:0]             pix_next, pix_reg;
    logic [WW+1:0]                wsum;

    assign rdy7     = !v7_reg || out_ready;
    assign rdy6     = !v6_reg || rdy7;
    assign rdy5     = !v5_reg || rdy6;
    assign in_ready = rdy5;

    assign fr  = WT_W'(in_frac_row);
    assign fc  = WT_W'(in_frac_col);
    assign wr0 = ONE_W - fr;
    assign wc0 = ONE_W - fc;

    // neighbour n: bit 1 picks the lower row, bit 0 the right column
    for (genvar n = 0; n < NBANK; n++) begin : g_nbr
        localparam logic [1:0] NID = 2'(n);
        logic [WT_W-1:0]   wa, wb;
        logic [2*WT_W-1:0] wprod;
        logic [1:0]        bank;
        logic              ok;
        logic [TERM_W-1:0] tprod;

        assign wa    = NID[1] ? fr : wr0;
        assign wb    = NID[0] ? fc : wc0;
        assign wprod = wa * wb;
        assign w_next[n] = wprod[WW-1:0];

        assign bank = {in_ctl.row_par ^ NID[1], in_ctl.col_par ^ NID[0]};
        assign ok   = (NID[1] ? in_ctl.row1_ok : in_ctl.row0_ok)
                   && (NID[0] ? in_ctl.col1_ok : in_ctl.col0_ok);
        assign p_next[n] = ok ? in_pix[bank] : '0;

        assign tprod     = w_reg[n] * p_reg[n];
        assign t_next[n] = tprod;
    end

    assign acc = ACC_W'(t_reg[0]) + ACC_W'(t_reg[1])
               + ACC_W'(t_reg[2]) + ACC_W'(t_reg[3]) + HALF_A;
    assign res = acc[ACC_W-1:SH];

    // saturate at full scale
    assign pix_next = (|res[RES_W-1:PIX_W]) ? '1 : res[PIX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (rdy5) begin
                v5_reg <= in_valid;
            end
            if (rdy6) begin
                v6_reg <= v5_reg;
            end
            if (rdy7) begin
                v7_reg <= v6_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            w_reg <= w_next;
            p_reg <= p_next;
        end
        if (rdy6) begin
            t_reg <= t_next;
        end
        if (rdy7) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_pixel = pix_reg;

    assign wsum = (WW + 2)'(w_reg[0]) + (WW + 2)'(w_reg[1])
                + (WW + 2)'(w_reg[2]) + (WW + 2)'(w_reg[3]);

    // bilinear weights always add up to one
    a_weight_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg |-> (wsum == ONE_SQ))
        else $error("bilinear weights do not sum to one");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v6_reg && !rdy6) |=> (v6_reg && $stable(t_reg)))
        else $error("term stage changed while stalled");

endmodule

// ===== rtl/bilinear_image_rotation.sv =====
`timescale 1ns / 1ps

// Bilinear rotation of a stored grayscale image about its center. Write beats
// (tuser = 0) load one 8-bit source pixel at (row, col); writes outside the
// image are dropped. Compute beats (tuser = 1) return one rotated pixel,
// sampled at src_row = x*sin + y*cos + rows/2, src_col = x*cos - y*sin +
// cols/2 with y = row - rows/2 and x = col - cols/2, using the cos_angle and
// sin_angle registers in signed fixed point with FRAC_BITS fraction bits.
// Neighbours that fall outside the image count as zero; the weighted sum is
// rounded half up and saturated at 255. The block takes one beat per clock
// while the output is not stalled, and a compute beat passes through input
// register, rotation multiply, coordinate add, bank read, weight multiply,
// pixel multiply, sum and saturate. The image sits in four banks split by
// row and column parity, so the four neighbours of any sample come from four
// separate single-read memories in the same cycle. Writes travel the same
// pipeline and commit at the bank-read stage, so every read sees exactly the
// writes that came before it in the stream. Reading a pixel that was never
// written returns an arbitrary value. Write the angle registers only while
// no compute beat is in flight.
module bilinear_image_rotation #(
    parameter int IMG_ROWS  = 28,
    parameter int IMG_COLS  = 28,
    parameter int FRAC_BITS = 14
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // row [4:0], col [9:5], source_pixel [17:10], zero fill
    input  logic        s_tuser,    // command: 0 write, 1 compute

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // pixel_out [7:0]

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    import bir_pkg::*;

    logic signed [ANG_W-1:0] cos_reg, sin_reg;

    logic      coord_valid, coord_ready;
    coord_t    coord;
    logic      nbr_valid, nbr_ready;
    nbr_ctl_t  nbr_ctl;
    logic [FRAC_BITS-1:0]          frac_row, frac_col;
    logic [NBANK-1:0][PIX_W-1:0]   bank_pix;

    // angle registers: hold between writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg <= COS_RESET;
            sin_reg <= SIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COS: cos_reg <= cfg_wdata;
                REG_SIN: sin_reg <= cfg_wdata;
            endcase
        end
    end

    // stages 1 to 3: center offset, rotation, source coordinate
    bir_coord #(
        .IMG_ROWS  (IMG_ROWS),
        .IMG_COLS  (IMG_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_coord (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_row    (s_tdata[4:0]),
        .in_col    (s_tdata[9:5]),
        .in_pix    (s_tdata[17:10]),
        .cos_angle (cos_reg),
        .sin_angle (sin_reg),
        .out_valid (coord_valid),
        .out_ready (coord_ready),
        .out_coord (coord)
    );

    // stage 4: commit writes, read four neighbours from the parity banks
    bir_store #(
        .IMG_ROWS  (IMG_ROWS),
        .IMG_COLS  (IMG_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (coord_valid),
        .in_ready     (coord_ready),
        .in_coord     (coord),
        .out_valid    (nbr_valid),
        .out_ready    (nbr_ready),
        .out_ctl      (nbr_ctl),
        .out_frac_row (frac_row),
        .out_frac_col (frac_col),
        .out_pix      (bank_pix)
    );

    // stages 5 to 7: weights, weighted pixels, round and saturate
    bir_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (nbr_valid),
        .in_ready    (nbr_ready),
        .in_ctl      (nbr_ctl),
        .in_frac_row (frac_row),
        .in_frac_col (frac_col),
        .in_pix      (bank_pix),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_pixel   (m_tdata)
    );

    // a free sink never backs up the source
    a_sink_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is free");

    a_cfg_cos: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && (cfg_index == REG_COS)) |=> (cos_reg == $past(cfg_wdata)))
        else $error("cos_angle write not taken");

    a_cfg_sin: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && (cfg_index == REG_SIN)) |=> (sin_reg == $past(cfg_wdata)))
        else $error("sin_angle write not taken");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the bilinear image rotation block.
module testbench;
    import bir_pkg::*;

    localparam int IMG_ROWS   = 28;
    localparam int IMG_COLS   = 28;
    localparam int FRAC_BITS  = 14;
    localparam longint UNIT   = longint'(1) << FRAC_BITS;
    // Pipeline is 7 deep; give write beats in flight room to land.
    localparam int SETTLE_CYCLES = 20;
    // Cycles without any accepted beat before the run is declared hung.
    localparam int STALL_LIMIT   = 5000;

    // One input beat before packing onto the bus.
    typedef struct packed {
        logic             cmd;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } rot_beat_t;

    // Who inserts bubbles: the sender, the receiver, both, or nobody.
    typedef enum logic [1:0] {
        GAP_NONE,
        GAP_SENDER,
        GAP_RECEIVER,
        GAP_BOTH
    } gap_mode_e;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = '0;

    // Beats waiting for the driver, and rotated pixels waiting for the monitor.
    rot_beat_t        pending_items[$];
    logic [PIX_W-1:0] expected_pixels[$];

    // Private copy of the block's state: the image and both angle registers.
    logic [PIX_W-1:0]        image_copy[IMG_ROWS*IMG_COLS];
    logic signed [ANG_W-1:0] cos_copy = COS_RESET;
    logic signed [ANG_W-1:0] sin_copy = SIN_RESET;

    gap_mode_e        gap_mode  = GAP_NONE;
    bit               src_hold  = 1'b0;
    int               errors    = 0;
    int               stall_count = 0;
    logic [PIX_W-1:0] want_pixel;

    bilinear_image_rotation #(
        .IMG_ROWS (IMG_ROWS),
        .IMG_COLS (IMG_COLS),
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // row [4:0], col [9:5], source_pixel [17:10], zero fill
        .s_tuser  (s_tuser),   // command: 0 write, 1 compute
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // pixel_out [7:0]
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Rotation predictor
    // ------------------------------------------------------------------

    // Stored pixel, or zero for a neighbour that lies off the image.
    function automatic longint pixel_at(longint r, longint c);
        if (r < 0 || r >= IMG_ROWS || c < 0 || c >= IMG_COLS) begin
            return 0;
        end
        return longint'(image_copy[r*IMG_COLS + c]);
    endfunction

    function automatic logic [PIX_W-1:0] rotated_pixel(logic [ROW_W-1:0] row,
                                                       logic [COL_W-1:0] col);
        longint y, x, src_r, src_c, r0, c0, fr, fc, wr0, wc0, acc, res;
        y = longint'(row) - IMG_ROWS/2;
        x = longint'(col) - IMG_COLS/2;
        // Inverse rotation back into source coordinates, in fixed point.
        src_r = x*longint'(sin_copy) + y*longint'(cos_copy) + (IMG_ROWS/2)*UNIT;
        src_c = x*longint'(cos_copy) - y*longint'(sin_copy) + (IMG_COLS/2)*UNIT;
        // Floor toward minus infinity; the fraction is always non-negative.
        fr  = src_r & (UNIT - 1);
        fc  = src_c & (UNIT - 1);
        r0  = (src_r - fr) >>> FRAC_BITS;
        c0  = (src_c - fc) >>> FRAC_BITS;
        wr0 = UNIT - fr;
        wc0 = UNIT - fc;
        acc = wr0*wc0*pixel_at(r0, c0)     + wr0*fc*pixel_at(r0, c0 + 1)
            + fr*wc0*pixel_at(r0 + 1, c0)  + fr*fc*pixel_at(r0 + 1, c0 + 1);
        // Round half up, then clamp to the pixel range.
        res = (acc + (longint'(1) << (2*FRAC_BITS - 1))) >>> (2*FRAC_BITS);
        if (res > 255) begin
            res = 255;
        end
        return res[PIX_W-1:0];
    endfunction

    // Apply one accepted beat: commit a write, or queue the rotated pixel.
    task automatic track_beat(logic cmd, logic [23:0] data);
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
        row = data[4:0];
        col = data[9:5];
        pix = data[17:10];
        if (cmd == CMD_WRITE) begin
            // Drop writes that land off the image.
            if (row < IMG_ROWS && col < IMG_COLS) begin
                image_copy[row*IMG_COLS + col] = pix;
            end
        end else begin
            expected_pixels.push_back(rotated_pixel(row, col));
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic bit take_gap(gap_mode_e mode, bit sender);
        int pct;
        case (mode)
            GAP_SENDER:   pct = sender ? 72 : 0;
            GAP_RECEIVER: pct = sender ? 0 : 72;
            GAP_BOTH:     pct = 11;
            default:      pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    function automatic rot_beat_t make_item(logic cmd, int row, int col, int pix);
        rot_beat_t b;
        b.cmd = cmd;
        b.row = row[ROW_W-1:0];
        b.col = col[COL_W-1:0];
        b.pix = pix[PIX_W-1:0];
        return b;
    endfunction

    // Mostly compute beats; overwrite the image now and then, a few writes
    // aimed off the image, and some requests from outside the image too.
    function automatic rot_beat_t random_item();
        rot_beat_t b;
        b.pix = PIX_W'($urandom_range(255));
        if ($urandom_range(99) < 70) begin
            b.cmd = CMD_COMPUTE;
            if ($urandom_range(99) < 80) begin
                b.row = ROW_W'($urandom_range(IMG_ROWS - 1));
                b.col = COL_W'($urandom_range(IMG_COLS - 1));
            end else begin
                b.row = ROW_W'($urandom_range(31));
                b.col = COL_W'($urandom_range(31));
            end
        end else begin
            b.cmd = CMD_WRITE;
            if ($urandom_range(99) < 90) begin
                b.row = ROW_W'($urandom_range(IMG_ROWS - 1));
                b.col = COL_W'($urandom_range(IMG_COLS - 1));
            end else begin
                b.row = ROW_W'($urandom_range(31));
                b.col = COL_W'($urandom_range(31));
            end
        end
        return b;
    endfunction

    // Block until every beat is sent and every pixel has come back, then let
    // trailing write beats clear the pipeline.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_items.size() != 0 || s_tvalid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write both angle registers; only called with the pipeline empty.
    task automatic set_angle(logic [15:0] cos_val, logic [15:0] sin_val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_COS;
        cfg_wdata <= cos_val;
        @(posedge aclk);
        cfg_index <= REG_SIN;
        cfg_wdata <= sin_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cos_copy = cos_val;
        sin_copy = sin_val;
        @(negedge aclk);
    endtask

    // One random phase; optionally hold the sender midway until the block is
    // completely empty, then resume.
    task automatic run_random(int count, gap_mode_e mode, bit pause_midway);
        gap_mode = mode;
        for (int i = 0; i < count; i++) begin
            pending_items.push_back(random_item());
        end
        if (pause_midway) begin
            do begin
                @(negedge aclk);
            end while (pending_items.size() > count/2);
            src_hold = 1'b1;
            do begin
                @(negedge aclk);
            end while (s_tvalid || expected_pixels.size() != 0);
            src_hold = 1'b0;
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued beats, hold a beat until it is taken, and
    // insert idle cycles as the current phase asks.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // Beat taken at this edge: advance the predictor with what was on the bus.
            if (s_tvalid && s_tready) begin
                track_beat(s_tuser, s_tdata);
            end
            if (s_tvalid && !s_tready) begin
                // Hold the current beat unchanged.
            end else if (pending_items.size() != 0 && !src_hold && !take_gap(gap_mode, 1'b1)) begin
                rot_beat_t nxt;
                nxt = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.cmd;
                s_tdata  <= {6'b0, nxt.pix, nxt.col, nxt.row};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each returned pixel with the oldest expectation and
    // stall the result side at random.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel_out: no beat expected, actual %0d", m_tdata);
                    errors++;
                end else begin
                    want_pixel = expected_pixels.pop_front();
                    if (m_tdata !== want_pixel) begin
                        $error("pixel_out mismatch: expected %0d, actual %0d",
                               want_pixel, m_tdata);
                        errors++;
                    end
                end
            end
            m_tready <= !take_gap(gap_mode, 1'b0);
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
        end
        if (stall_count >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int rand_cos;
        int rand_sin;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Load every source pixel first: no sample may ever touch an
        // unwritten entry.
        gap_mode = GAP_NONE;
        for (int r = 0; r < IMG_ROWS; r++) begin
            for (int c = 0; c < IMG_COLS; c++) begin
                pending_items.push_back(make_item(CMD_WRITE, r, c, $urandom_range(255)));
            end
        end

        // Directed beats under the reset angle (identity): every sample
        // lands on an exact coordinate, so every neighbour but the base one weighs zero.
        // Writes off the image must be dropped.
        pending_items.push_back(make_item(CMD_WRITE, 28, 0, 8'hFF));
        pending_items.push_back(make_item(CMD_WRITE, 0, 28, 8'hAA));
        pending_items.push_back(make_item(CMD_WRITE, 31, 31, 8'h55));
        pending_items.push_back(make_item(CMD_WRITE, 29, 13, 8'h01));
        pending_items.push_back(make_item(CMD_COMPUTE, 0, 0, 0));
        pending_items.push_back(make_item(CMD_COMPUTE, 27, 27, 0));
        pending_items.push_back(make_item(CMD_COMPUTE, 31, 31, 0));
        pending_items.push_back(make_item(CMD_COMPUTE, 0, 31, 0));
        pending_items.push_back(make_item(CMD_COMPUTE, 31, 0, 0));
        pending_items.push_back(make_item(CMD_COMPUTE, 28, 3, 0));
        pending_items.push_back(make_item(CMD_COMPUTE, 14, 14, 0));
        // Extremes of the source pixel, read back straight after the write.
        pending_items.push_back(make_item(CMD_WRITE, 14, 14, 0));
        pending_items.push_back(make_item(CMD_COMPUTE, 14, 14, 0));
        pending_items.push_back(make_item(CMD_WRITE, 14, 14, 255));
        pending_items.push_back(make_item(CMD_COMPUTE, 14, 14, 0));
        pending_items.push_back(make_item(CMD_WRITE, 0, 0, 8'h5A));
        pending_items.push_back(make_item(CMD_COMPUTE, 0, 0, 0));
        pending_items.push_back(make_item(CMD_WRITE, 27, 27, 8'hA5));
        pending_items.push_back(make_item(CMD_COMPUTE, 27, 27, 0));
        wait_drained();

        // Sweep the angle through its extremes and a few oblique settings,
        // each under one of the idle patterns in turn.
        set_angle(16'sd16384, 16'sd0);
        run_random(140, GAP_SENDER, 1'b0);
        set_angle(16'sd0, 16'sd16384);
        run_random(140, GAP_RECEIVER, 1'b0);
        set_angle(16'sd11585, 16'sd11585);
        run_random(140, GAP_BOTH, 1'b0);
        set_angle(-16'sd16384, 16'sd0);
        run_random(140, GAP_NONE, 1'b0);
        set_angle(16'sd0, -16'sd16384);
        run_random(140, GAP_SENDER, 1'b0);
        rand_cos = int'($urandom_range(32768)) - 16384;
        rand_sin = int'($urandom_range(32768)) - 16384;
        set_angle(rand_cos[15:0], rand_sin[15:0]);
        run_random(140, GAP_RECEIVER, 1'b0);
        // Register values beyond the unit circle are used as given.
        set_angle(16'h8000, 16'h7FFF);
        run_random(140, GAP_BOTH, 1'b0);
        set_angle(16'sd13377, -16'sd9459);
        run_random(140, GAP_SENDER, 1'b1);

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bir_pkg.sv
rtl/bir_ram.sv
rtl/bir_coord.sv
rtl/bir_store.sv
rtl/bir_blend.sv
rtl/bilinear_image_rotation.sv
tb/testbench.sv
